// ----- rtl/core/i2cbm_pkg.sv -----
`timescale 1ns / 1ps

package i2cbm_pkg;

   localparam logic [15:0] TIMEOUT_RESET  = 16'd1500;
   localparam logic [3:0]  BITS_PER_FRAME = 4'd9;
   localparam logic [16:0] TICK_MAX       = 17'h1FFFF;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] CMD_SCL_RISE = 2'd0;
   localparam logic [1:0] CMD_SDA_EDGE = 2'd1;
   localparam logic [1:0] CMD_TICK     = 2'd2;

   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_STOP    = 2'd1;
   localparam logic [1:0] KIND_BYTE    = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic       sda_level;
      logic       scl_level;
   } req_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic       is_address;
      logic       read_flag;
      logic       acked;
      logic [3:0] bits_seen;
   } rsp_word_type;

   typedef enum logic [1:0] {
      OP_BIT,
      OP_START,
      OP_STOP,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sda;
   } op_word_type;

   // front to queue
   typedef struct packed {
      logic        push;
      op_word_type data;
   } q_push_type;

   // queue to back and top
   typedef struct packed {
      logic                 valid;
      logic                 full;
      logic [Q_CNT_W-1:0]   count;
      op_word_type          data;
   } q_status_type;

endpackage

// ----- rtl/core/i2cbm_front.sv -----
`timescale 1ns / 1ps

module i2cbm_front (
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  i2cbm_pkg::req_word_type req_word,
   output i2cbm_pkg::q_push_type   push_out
);

   logic             keep;
   i2cbm_pkg::op_type op;

   always_comb begin
      keep = 1'b0;
      op   = i2cbm_pkg::OP_BIT;
      case (req_word.command)
         i2cbm_pkg::CMD_SCL_RISE: begin
            keep = 1'b1;
            op   = i2cbm_pkg::OP_BIT;
         end
         i2cbm_pkg::CMD_SDA_EDGE: begin
            // SDA edge with SCL low carries no condition
            keep = req_word.scl_level;
            op   = req_word.sda_level ? i2cbm_pkg::OP_STOP : i2cbm_pkg::OP_START;
         end
         i2cbm_pkg::CMD_TICK: begin
            keep = 1'b1;
            op   = i2cbm_pkg::OP_TICK;
         end
         default: begin
            keep = 1'b0;
            op   = i2cbm_pkg::OP_BIT;
         end
      endcase
   end

   assign push_out.push     = req_valid && !req_stall && keep;
   assign push_out.data.op  = op;
   assign push_out.data.sda = req_word.sda_level;

endmodule

// ----- rtl/core/i2cbm_queue.sv -----
`timescale 1ns / 1ps

module i2cbm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  i2cbm_pkg::q_push_type   push_in,
   input  logic                    pop,
   output i2cbm_pkg::q_status_type status
);

   i2cbm_pkg::op_word_type             mem_ff [i2cbm_pkg::Q_DEPTH];
   logic [i2cbm_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [i2cbm_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [i2cbm_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   logic                               do_push, do_pop;

   localparam logic [i2cbm_pkg::Q_CNT_W-1:0] FULL_CNT =
      i2cbm_pkg::Q_CNT_W'(i2cbm_pkg::Q_DEPTH);
   localparam logic [i2cbm_pkg::Q_PTR_W-1:0] LAST_PTR =
      i2cbm_pkg::Q_PTR_W'(i2cbm_pkg::Q_DEPTH - 1);

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign status.count = count_ff;
   assign status.data  = mem_ff[rd_ptr_ff];

   assign do_push = push_in.push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_in.data;
      end
   end

endmodule

// ----- rtl/core/i2cbm_back.sv -----
`timescale 1ns / 1ps

module i2cbm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  i2cbm_pkg::q_status_type q_status,
   output logic                    pop,
   input  logic                    csr_valid,
   input  logic [15:0]             csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output i2cbm_pkg::rsp_word_type rsp_word
);

   logic [15:0]             timeout_ff, timeout_in;
   logic [3:0]              bits_left_ff, bits_left_in;
   logic [7:0]              shift_byte_ff, shift_byte_in;
   logic                    rw_bit_ff, rw_bit_in;
   logic                    expect_address_ff, expect_address_in;
   logic [16:0]             idle_ticks_ff, idle_ticks_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   i2cbm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                    out_free;
   logic [3:0]              bits_dec;
   logic [16:0]             idle_inc;
   i2cbm_pkg::op_word_type  cur;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = q_status.valid && out_free;
   assign cur       = q_status.data;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign bits_dec = bits_left_ff - 4'd1;
   assign idle_inc = (idle_ticks_ff == i2cbm_pkg::TICK_MAX) ? idle_ticks_ff
                                                            : idle_ticks_ff + 17'd1;

   always_comb begin
      timeout_in        = csr_valid ? csr_data : timeout_ff;
      bits_left_in      = bits_left_ff;
      shift_byte_in     = shift_byte_ff;
      rw_bit_in         = rw_bit_ff;
      expect_address_in = expect_address_ff;
      idle_ticks_in     = idle_ticks_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_word_in       = rsp_word_ff;

      if (pop) begin
         case (cur.op)
            i2cbm_pkg::OP_BIT: begin
               if (bits_left_ff != 4'd0) begin
                  bits_left_in = bits_dec;
                  if (bits_dec == 4'd0) begin
                     rsp_valid_in           = 1'b1;
                     rsp_word_in.kind       = i2cbm_pkg::KIND_BYTE;
                     rsp_word_in.byte_value = shift_byte_ff;
                     rsp_word_in.is_address = expect_address_ff;
                     rsp_word_in.read_flag  = expect_address_ff && rw_bit_ff;
                     rsp_word_in.acked      = !cur.sda;
                     rsp_word_in.bits_seen  = i2cbm_pkg::BITS_PER_FRAME;
                     shift_byte_in          = 8'd0;
                     bits_left_in           = i2cbm_pkg::BITS_PER_FRAME;
                     expect_address_in      = 1'b0;
                     idle_ticks_in          = 17'd0;
                  end else if (bits_dec == 4'd1 && expect_address_ff) begin
                     rw_bit_in = cur.sda;
                  end else begin
                     shift_byte_in = {shift_byte_ff[6:0], cur.sda};
                  end
               end
            end
            i2cbm_pkg::OP_START: begin
               bits_left_in      = i2cbm_pkg::BITS_PER_FRAME;
               shift_byte_in     = 8'd0;
               rw_bit_in         = 1'b0;
               expect_address_in = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_word_in       = '0;
               rsp_word_in.kind  = i2cbm_pkg::KIND_START;
            end
            i2cbm_pkg::OP_STOP: begin
               bits_left_in      = 4'd0;
               shift_byte_in     = 8'd0;
               expect_address_in = 1'b0;
               idle_ticks_in     = 17'd0;
               rsp_valid_in      = 1'b1;
               rsp_word_in       = '0;
               rsp_word_in.kind  = i2cbm_pkg::KIND_STOP;
            end
            i2cbm_pkg::OP_TICK: begin
               if (bits_left_ff == 4'd0) begin
                  idle_ticks_in = 17'd0;
               end else if (idle_inc > {1'b0, timeout_ff}) begin
                  rsp_valid_in           = 1'b1;
                  rsp_word_in.kind       = i2cbm_pkg::KIND_TIMEOUT;
                  rsp_word_in.byte_value = shift_byte_ff;
                  rsp_word_in.is_address = expect_address_ff;
                  rsp_word_in.read_flag  = expect_address_ff && rw_bit_ff;
                  rsp_word_in.acked      = 1'b0;
                  rsp_word_in.bits_seen  = i2cbm_pkg::BITS_PER_FRAME - bits_left_ff;
                  shift_byte_in          = 8'd0;
                  bits_left_in           = i2cbm_pkg::BITS_PER_FRAME;
                  expect_address_in      = 1'b0;
                  idle_ticks_in          = 17'd0;
               end else begin
                  idle_ticks_in = idle_inc;
               end
            end
            default: begin
               bits_left_in = bits_left_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff        <= i2cbm_pkg::TIMEOUT_RESET;
         bits_left_ff      <= 4'd0;
         shift_byte_ff     <= 8'd0;
         rw_bit_ff         <= 1'b0;
         expect_address_ff <= 1'b0;
         idle_ticks_ff     <= 17'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         timeout_ff        <= timeout_in;
         bits_left_ff      <= bits_left_in;
         shift_byte_ff     <= shift_byte_in;
         rw_bit_ff         <= rw_bit_in;
         expect_address_ff <= expect_address_in;
         idle_ticks_ff     <= idle_ticks_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ----- rtl/core/i2c_bus_monitor_decoder.sv -----
`timescale 1ns / 1ps

// channel  handshake                  word
// req      req_valid / req_stall      req_word_type: command, sda_level, scl_level
// rsp      rsp_valid / rsp_stall      rsp_word_type: kind, byte_value, flags, bits_seen
// csr      csr_valid / csr_ready      csr_data: timeout_ticks
//
// One word per cycle sustained while rsp_stall is low; a result passes through
// the queue register, then the output register.
// Synchronous reset: bus idle, timeout_ticks back to 1500.
// rsp_stall holds the output register and halts the back end; the two-entry
// queue then fills and req_stall rises once both entries are taken.
// csr_ready is always high.

module i2c_bus_monitor_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  i2cbm_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output i2cbm_pkg::rsp_word_type rsp_word,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [15:0]             csr_data
);

   i2cbm_pkg::q_push_type   q_push;
   i2cbm_pkg::q_status_type q_status;
   logic                    pop;

   assign req_stall = q_status.full;
   assign csr_ready = 1'b1;

   i2cbm_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .push_out  (q_push)
   );

   i2cbm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (q_push),
      .pop     (pop),
      .status  (q_status)
   );

   i2cbm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop       (pop),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= i2cbm_pkg::Q_CNT_W'(i2cbm_pkg::Q_DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !pop)
      else $error("back end advanced while output held");

   a_cond_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.kind == i2cbm_pkg::KIND_START ||
                     rsp_word.kind == i2cbm_pkg::KIND_STOP))
      |-> (rsp_word.byte_value == 8'd0 && rsp_word.bits_seen == 4'd0))
      else $error("start/stop word carries byte data");

   a_byte_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.kind == i2cbm_pkg::KIND_BYTE)
      |-> (rsp_word.bits_seen == i2cbm_pkg::BITS_PER_FRAME))
      else $error("byte word without nine bits");

endmodule
